// File: sv/bat_pkg.sv
package bat_pkg;

  localparam int unsigned MaxSegments = 63;
  localparam int unsigned CordicIter  = 24;
  localparam int unsigned SegW        = 6;
  localparam int unsigned IterW       = $clog2(CordicIter);
  localparam int unsigned DivW        = 48;
  localparam int unsigned DivisorW    = 21;

  localparam logic [SegW-1:0]  SegMax   = SegW'(MaxSegments);
  localparam logic [SegW-1:0]  SegReset = SegW'(32);
  localparam logic [IterW-1:0] IterLast = IterW'(CordicIter - 1);

  localparam logic signed [63:0] QuarterTurn = 64'sd1073741824;
  localparam logic signed [63:0] GainQ32     = 64'sd2608131496;
  localparam logic [63:0]        ClampMag    = 64'd1 << 58;

  typedef enum logic [1:0] {
    SHIFT_1,
    SHIFT_16,
    SHIFT_32
  } mul_shift_e;

  typedef struct packed {
    logic              start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    mul_shift_e        shift;
  } mul_req_t;

  typedef struct packed {
    logic                start;
    logic [DivW-1:0]     dividend;
    logic [DivisorW-1:0] divisor;
  } div_req_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic [31:0] atan_lut(input logic [IterW-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: sv/bat_mul.sv
// Signed 64x64 multiply, round half away from zero, shift right, clamp to 2^58.
// Four 32x32 partial products, one per cycle.
module bat_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bat_pkg::mul_req_t  req_i,
  output logic               done_o,
  output logic signed [63:0] res_o
);

  logic                busy_q;
  logic [2:0]          cnt_q;
  logic                done_q;
  logic                neg_q;
  logic [63:0]         ua_q;
  logic [63:0]         ub_q;
  logic [63:0]         pp_q;
  logic [127:0]        acc_q;
  bat_pkg::mul_shift_e sh_q;
  logic signed [63:0]  res_q;

  logic [31:0]  opa;
  logic [31:0]  opb;
  logic [6:0]   shamt;
  logic [127:0] pp_ext;
  logic [127:0] rnd;
  logic [127:0] rounded;
  logic [127:0] shifted;
  logic [63:0]  mag;

  assign opa = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
  assign opb = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];

  always_comb begin
    // align the product taken in the previous cycle
    if (cnt_q == 3'd1) begin
      shamt = 7'd0;
    end else if (cnt_q == 3'd4) begin
      shamt = 7'd64;
    end else begin
      shamt = 7'd32;
    end
    pp_ext = {64'd0, pp_q} << shamt;
  end

  always_comb begin
    case (sh_q)
      bat_pkg::SHIFT_1:  rnd = 128'd1;
      bat_pkg::SHIFT_16: rnd = 128'd1 << 15;
      bat_pkg::SHIFT_32: rnd = 128'd1 << 31;
      default:           rnd = 128'd0;
    endcase
    rounded = acc_q + rnd;
    case (sh_q)
      bat_pkg::SHIFT_1:  shifted = rounded >> 1;
      bat_pkg::SHIFT_16: shifted = rounded >> 16;
      bat_pkg::SHIFT_32: shifted = rounded >> 32;
      default:           shifted = rounded;
    endcase
    mag = (shifted > {64'd0, bat_pkg::ClampMag}) ? bat_pkg::ClampMag : shifted[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd5) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.a[63] ^ req_i.b[63];
      ua_q  <= req_i.a[63] ? 64'(-req_i.a) : 64'(req_i.a);
      ub_q  <= req_i.b[63] ? 64'(-req_i.b) : 64'(req_i.b);
      sh_q  <= req_i.shift;
      acc_q <= 128'd0;
    end else if (busy_q) begin
      if (cnt_q < 3'd4) begin
        pp_q <= opa * opb;
      end
      if (cnt_q >= 3'd1 && cnt_q <= 3'd4) begin
        acc_q <= acc_q + pp_ext;
      end
      if (cnt_q == 3'd5) begin
        res_q <= neg_q ? 64'(-mag) : mag;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: sv/bat_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
module bat_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bat_pkg::div_req_t                req_i,
  output logic                             done_o,
  output logic [bat_pkg::DivW-1:0]         quot_o,
  output logic [bat_pkg::DivisorW-1:0]     rem_o
);

  localparam int unsigned CntW = $clog2(bat_pkg::DivW);
  localparam logic [CntW-1:0] CntLast = CntW'(bat_pkg::DivW - 1);

  logic                            busy_q;
  logic                            done_q;
  logic [CntW-1:0]                 cnt_q;
  logic [bat_pkg::DivW-1:0]        quot_q;
  logic [bat_pkg::DivisorW-1:0]    rem_q;
  logic [bat_pkg::DivisorW-1:0]    dvs_q;

  logic [bat_pkg::DivisorW:0] trial;
  logic [bat_pkg::DivisorW:0] diff;
  logic                       ge;

  assign trial = {rem_q, quot_q[bat_pkg::DivW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.dividend;
      rem_q  <= '0;
      dvs_q  <= req_i.divisor;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[bat_pkg::DivisorW-1:0] : trial[bat_pkg::DivisorW-1:0];
      quot_q <= {quot_q[bat_pkg::DivW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// File: sv/bulge_arc_tessellator.sv
// Bulge arc tessellator. Takes one arc word (start, end, plane z, bulge =
// tan(sweep/4)) and returns segment_count+1 vertex words along the arc, the
// last one flagged by tlast. The center sits on the side the bulge sign
// implies, beyond the chord when |bulge| > 1. A zero bulge or coincident ends
// give a single word with tuser set, tlast set and all data zero. One arc is
// worked at a time: s_axis_tready is high only while the sequencer is idle,
// also while the output register still holds a finished word that waits for
// m_axis_tready. Setup runs two passes of the shared divider, three passes of
// the shared multiplier and 24 CORDIC vectoring steps; each vertex then needs
// up to three quarter turns, 24 CORDIC rotation steps and two gain
// multiplies. The CORDIC step, the multiplier and the divider are each a
// single shared unit. segment_count sits at APB byte address 0; a value of
// zero acts as one.
module bulge_arc_tessellator (
  input  logic         clk_i,
  input  logic         rst_ni,
  // start_x, start_y, end_x, end_y, plane_z (32 each), bulge (21), zero fill
  input  logic [183:0] s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vertex_x, vertex_y, vertex_z (32 each), vertex_index (6), zero fill
  output logic [103:0] m_axis_tdata,
  output logic         m_axis_tuser,  // status: 1 marks an invalid arc
  output logic         m_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic RegSegCount = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_BSQ, ST_KDIV, ST_M1, ST_M2, ST_SWEEP, ST_SDIV,
    ST_VSTART, ST_QUAD, ST_ROT, ST_GX, ST_GY, ST_PUSH
  } state_e;

  // control
  state_e                       state_q;
  logic                         out_valid_q;
  logic [bat_pkg::SegW-1:0]     seg_q;
  logic [bat_pkg::IterW-1:0]    it_q;
  logic [bat_pkg::SegW-1:0]     vidx_q;
  bat_pkg::mul_req_t            mul_req_q;
  bat_pkg::div_req_t            div_req_q;

  // arc operands
  logic signed [31:0] sx_q, sy_q, ex_q, ey_q, z_q;
  logic signed [20:0] b_q;
  logic signed [63:0] dx_q, dy_q, kq_q, vx_q, vy_q, cx_q, cy_q, gx_q;
  logic               num_neg_q;
  logic               sweep_neg_q;
  logic [bat_pkg::DivW-1:0] q0_q, qacc_q;
  logic [bat_pkg::SegW-1:0] r0_q, racc_q;

  // shared CORDIC registers
  logic signed [63:0] x_q, y_q, ang_q;

  // pending and output words
  logic [31:0]              pend_x_q, pend_y_q, pend_z_q;
  logic [bat_pkg::SegW-1:0] pend_idx_q;
  logic                     pend_status_q, pend_last_q;
  logic [31:0]              out_x_q, out_y_q, out_z_q;
  logic [bat_pkg::SegW-1:0] out_idx_q;
  logic                     out_status_q, out_last_q;

  // unit results
  logic                             mul_done;
  logic signed [63:0]               mul_res;
  logic                             div_done;
  logic [bat_pkg::DivW-1:0]         div_quot;
  logic [bat_pkg::DivisorW-1:0]     div_rem;

  logic                     in_acc;
  logic                     out_load;
  logic                     cfg_wr;
  logic [bat_pkg::SegW-1:0] n_w;
  logic                     invalid_w;
  logic signed [63:0]       num_w;
  logic [63:0]              num_abs;
  logic [20:0]              b_abs;
  logic signed [63:0]       kq_w;
  logic signed [63:0]       vx_w, vy_w;
  logic                     vect;
  logic                     ccw;
  logic signed [63:0]       atan_w;
  logic signed [63:0]       x_nx, y_nx, ang_nx;
  logic signed [63:0]       sweep_w;
  logic [63:0]              sweep_abs;
  logic                     quad_pos, quad_neg;
  logic [bat_pkg::SegW:0]   rsum;

  function automatic logic [31:0] sat_round(input logic signed [63:0] c,
                                            input logic signed [63:0] g);
    logic signed [63:0] s;
    logic signed [63:0] t;
    logic [31:0]        r;
    s = c + g + 64'sd128;
    t = s >>> 8;
    if (t > 64'sd2147483647) begin
      r = 32'h7FFFFFFF;
    end else if (t < -64'sd2147483648) begin
      r = 32'h80000000;
    end else begin
      r = t[31:0];
    end
    return r;
  endfunction

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == ST_PUSH) && (!out_valid_q || m_axis_tready);
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == RegSegCount);

  always_comb begin
    if (seg_q == '0) begin
      n_w = bat_pkg::SegW'(1);
    end else if (seg_q > bat_pkg::SegMax) begin
      n_w = bat_pkg::SegMax;
    end else begin
      n_w = seg_q;
    end
  end

  assign invalid_w = (b_q == '0) || ((sx_q == ex_q) && (sy_q == ey_q));

  // k numerator (2^32 - b^2) * 64 and its magnitude for the divider
  assign num_w   = (64'sd4294967296 - mul_res) <<< 6;
  assign num_abs = num_w[63] ? 64'(-num_w) : 64'(num_w);
  assign b_abs   = b_q[20] ? 21'(-b_q) : 21'(b_q);
  assign kq_w    = (num_neg_q ^ b_q[20]) ? -$signed({16'd0, div_quot})
                                         : $signed({16'd0, div_quot});

  // start minus center
  assign vx_w = mul_res - (dx_q <<< 7);
  assign vy_w = -(dy_q <<< 7) - mul_res;

  // one CORDIC step: vectoring during the sweep pass, rotation per vertex
  assign vect   = (state_q == ST_SWEEP);
  assign ccw    = vect ? !(!y_q[63] && (y_q != '0)) : !ang_q[63];
  assign atan_w = $signed({32'd0, bat_pkg::atan_lut(it_q)});
  assign x_nx   = ccw ? x_q - (y_q >>> it_q) : x_q + (y_q >>> it_q);
  assign y_nx   = ccw ? y_q + (x_q >>> it_q) : y_q - (x_q >>> it_q);
  assign ang_nx = ccw ? ang_q - atan_w : ang_q + atan_w;

  assign sweep_w   = ang_nx <<< 2;
  assign sweep_abs = sweep_w[63] ? 64'(-sweep_w) : 64'(sweep_w);

  assign quad_pos = ang_q > bat_pkg::QuarterTurn;
  assign quad_neg = ang_q < -bat_pkg::QuarterTurn;

  assign rsum = {1'b0, racc_q} + {1'b0, r0_q};

  // sequencer, unit requests and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      seg_q       <= bat_pkg::SegReset;
      it_q        <= '0;
      vidx_q      <= '0;
      mul_req_q   <= '0;
      div_req_q   <= '0;
    end else begin
      mul_req_q.start <= 1'b0;
      div_req_q.start <= 1'b0;
      if (cfg_wr) begin
        seg_q <= pwdata[bat_pkg::SegW-1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (invalid_w) begin
            state_q <= ST_PUSH;
          end else begin
            mul_req_q <= '{start: 1'b1, a: 64'(b_q), b: 64'(b_q) <<< 1,
                           shift: bat_pkg::SHIFT_1};
            state_q   <= ST_BSQ;
          end
        end
        ST_BSQ: begin
          if (mul_done) begin
            div_req_q <= '{start: 1'b1, dividend: num_abs[bat_pkg::DivW-1:0],
                           divisor: b_abs};
            state_q   <= ST_KDIV;
          end
        end
        ST_KDIV: begin
          if (div_done) begin
            mul_req_q <= '{start: 1'b1, a: kq_w, b: dy_q, shift: bat_pkg::SHIFT_16};
            state_q   <= ST_M1;
          end
        end
        ST_M1: begin
          if (mul_done) begin
            mul_req_q <= '{start: 1'b1, a: kq_q, b: dx_q, shift: bat_pkg::SHIFT_16};
            state_q   <= ST_M2;
          end
        end
        ST_M2: begin
          if (mul_done) begin
            it_q    <= '0;
            state_q <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          it_q <= it_q + 1'b1;
          if (it_q == bat_pkg::IterLast) begin
            div_req_q <= '{start: 1'b1, dividend: sweep_abs[bat_pkg::DivW-1:0],
                           divisor: {15'd0, n_w}};
            state_q   <= ST_SDIV;
          end
        end
        ST_SDIV: begin
          if (div_done) begin
            vidx_q  <= '0;
            state_q <= ST_VSTART;
          end
        end
        ST_VSTART: begin
          state_q <= ST_QUAD;
        end
        ST_QUAD: begin
          if (!quad_pos && !quad_neg) begin
            it_q    <= '0;
            state_q <= ST_ROT;
          end
        end
        ST_ROT: begin
          it_q <= it_q + 1'b1;
          if (it_q == bat_pkg::IterLast) begin
            mul_req_q <= '{start: 1'b1, a: x_nx, b: bat_pkg::GainQ32,
                           shift: bat_pkg::SHIFT_32};
            state_q   <= ST_GX;
          end
        end
        ST_GX: begin
          if (mul_done) begin
            mul_req_q <= '{start: 1'b1, a: y_q, b: bat_pkg::GainQ32,
                           shift: bat_pkg::SHIFT_32};
            state_q   <= ST_GY;
          end
        end
        ST_GY: begin
          if (mul_done) begin
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (out_load) begin
            if (pend_last_q) begin
              state_q <= ST_IDLE;
            end else begin
              vidx_q  <= vidx_q + 1'b1;
              state_q <= ST_VSTART;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          sx_q <= s_axis_tdata[31:0];
          sy_q <= s_axis_tdata[63:32];
          ex_q <= s_axis_tdata[95:64];
          ey_q <= s_axis_tdata[127:96];
          z_q  <= s_axis_tdata[159:128];
          b_q  <= s_axis_tdata[180:160];
        end
      end
      ST_CHECK: begin
        dx_q <= 64'(ex_q) - 64'(sx_q);
        dy_q <= 64'(ey_q) - 64'(sy_q);
        // invalid arc: one zero word with status set
        pend_x_q      <= '0;
        pend_y_q      <= '0;
        pend_z_q      <= '0;
        pend_idx_q    <= '0;
        pend_status_q <= 1'b1;
        pend_last_q   <= 1'b1;
      end
      ST_BSQ: begin
        if (mul_done) begin
          num_neg_q <= num_w[63];
        end
      end
      ST_KDIV: begin
        if (div_done) begin
          kq_q <= kq_w;
        end
      end
      ST_M1: begin
        if (mul_done) begin
          vx_q <= vx_w;
          cx_q <= (64'(sx_q) <<< 8) - vx_w;
        end
      end
      ST_M2: begin
        if (mul_done) begin
          vy_q  <= vy_w;
          cy_q  <= (64'(sy_q) <<< 8) - vy_w;
          x_q   <= bat_pkg::QuarterTurn;
          y_q   <= 64'(b_q) <<< 14;
          ang_q <= '0;
        end
      end
      ST_SWEEP: begin
        x_q   <= x_nx;
        y_q   <= y_nx;
        ang_q <= ang_nx;
        if (it_q == bat_pkg::IterLast) begin
          sweep_neg_q <= sweep_w[63];
        end
      end
      ST_SDIV: begin
        if (div_done) begin
          q0_q   <= div_quot;
          r0_q   <= div_rem[bat_pkg::SegW-1:0];
          qacc_q <= '0;
          racc_q <= '0;
        end
      end
      ST_VSTART: begin
        x_q   <= vx_q;
        y_q   <= vy_q;
        ang_q <= sweep_neg_q ? -$signed({16'd0, qacc_q}) : $signed({16'd0, qacc_q});
      end
      ST_QUAD: begin
        // bring the angle into +-1/4 turn with exact quarter turns
        if (quad_pos) begin
          x_q   <= -y_q;
          y_q   <= x_q;
          ang_q <= ang_q - bat_pkg::QuarterTurn;
        end else if (quad_neg) begin
          x_q   <= y_q;
          y_q   <= -x_q;
          ang_q <= ang_q + bat_pkg::QuarterTurn;
        end
      end
      ST_ROT: begin
        x_q   <= x_nx;
        y_q   <= y_nx;
        ang_q <= ang_nx;
      end
      ST_GX: begin
        if (mul_done) begin
          gx_q <= mul_res;
        end
      end
      ST_GY: begin
        if (mul_done) begin
          pend_x_q      <= sat_round(cx_q, gx_q);
          pend_y_q      <= sat_round(cy_q, mul_res);
          pend_z_q      <= z_q;
          pend_idx_q    <= vidx_q;
          pend_status_q <= 1'b0;
          pend_last_q   <= (vidx_q == n_w);
        end
      end
      ST_PUSH: begin
        if (out_load) begin
          // advance the vertex angle sweep*i/n by quotient and remainder
          if (rsum >= {1'b0, n_w}) begin
            racc_q <= bat_pkg::SegW'(rsum - {1'b0, n_w});
            qacc_q <= qacc_q + q0_q + 1'b1;
          end else begin
            racc_q <= rsum[bat_pkg::SegW-1:0];
            qacc_q <= qacc_q + q0_q;
          end
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_x_q      <= pend_x_q;
      out_y_q      <= pend_y_q;
      out_z_q      <= pend_z_q;
      out_idx_q    <= pend_idx_q;
      out_status_q <= pend_status_q;
      out_last_q   <= pend_last_q;
    end
  end

  bat_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req_q),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  bat_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .done_o (div_done),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_idx_q, out_z_q, out_y_q, out_x_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;
  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == RegSegCount) ? {26'd0, seg_q} : 32'd0;

endmodule

// File: sv/bat_checker.sv
module bat_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic [183:0] s_axis_tdata,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         m_axis_tlast,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // one arc at a time: no second word taken right after one
  a_one_arc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while arc in work");

  // invalid arc: single zero word that closes the arc
  a_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("invalid word not final or not zero");

  // a vertex that is not the last never carries the invalid flag
  a_mid_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser)
    else $error("invalid flag on inner vertex");

endmodule

bind bulge_arc_tessellator bat_checker u_bat_checker (.*);

// File: verif/tb_bulge_arc_tessellator.sv
`default_nettype none

module tb_bulge_arc_tessellator;
  import bat_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Register byte addresses on the APB port
  localparam logic [2:0] ADDR_SEGMENT_COUNT = 3'd0;

  // Vertex status codes carried on m_axis_tuser
  typedef enum logic {
    ST_VALID   = 1'b0,
    ST_INVALID = 1'b1
  } vtx_status_e;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 300;
  localparam int unsigned RandomArcs    = 330;

  // atan(2^-k), 2^32 units per turn
  localparam longint AtanStep [0:31] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
    64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
    64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001,
    64'h00000000, 64'h00000000
  };

  typedef struct {
    logic signed [31:0] sx, sy, ex, ey, z;
    logic signed [20:0] bulge;
  } arc_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic [5:0]         idx;
    vtx_status_e        status;
    logic               last;
  } vertex_t;

  // Directed row: invalid arcs carry their result typed in
  typedef struct {
    arc_t arc;
    logic typed_invalid;
  } drow_t;

  logic         clk_i;
  logic         rst_ni;
  // start_x, start_y, end_x, end_y, plane_z (32 each), bulge (21), zero fill
  logic [183:0] s_axis_tdata;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // vertex_x, vertex_y, vertex_z (32 each), vertex_index (6), zero fill
  logic [103:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic         psel, penable, pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata, prdata;
  logic         pready;

  bulge_arc_tessellator dut (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tlast, .m_axis_tvalid, .m_axis_tready,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  vertex_t     vertex_q [$];
  logic [5:0]  seg_count_q;     // shadow of the segment_count register
  int unsigned err_cnt;
  int unsigned quiet_cycles;
  bit          no_idle;         // final stretch runs at full rate

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // round(a*b / 2^s) half away from zero, magnitude clamped to 2^58
  function automatic longint round_mul(input longint a, input longint b, input int s);
    logic [63:0]  ua, ub, mag;
    logic [127:0] p, q;
    logic         neg;
    neg = (a < 0) != (b < 0);
    ua  = a < 0 ? 64'(-a) : 64'(a);
    ub  = b < 0 ? 64'(-b) : 64'(b);
    p   = {64'd0, ua} * {64'd0, ub};
    p   = p + (128'd1 << (s - 1));
    q   = p >> s;
    if (q[127:64] != 0 || q[63:0] > ClampMag) mag = ClampMag;
    else mag = q[63:0];
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic signed [31:0] sat_q16(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Work out the vertex words one arc produces and queue them
  task automatic tessellate_arc(input arc_t a);
    longint  n, b, dx, dy, kq, vx, vy, cx, cy, sweep, x, y, z, t, phi;
    vertex_t v;
    n = seg_count_q;
    if (n < 1) n = 1;
    if (n > MaxSegments) n = MaxSegments;
    b = a.bulge;
    if (b == 0 || (a.sx == a.ex && a.sy == a.ey)) begin
      v = '{x: 0, y: 0, z: 0, idx: 0, status: ST_INVALID, last: 1'b1};
      vertex_q.push_back(v);
      return;
    end
    dx = longint'(a.ex) - longint'(a.sx);
    dy = longint'(a.ey) - longint'(a.sy);
    kq = ((64'sd4294967296 - b * b) * 64) / b;
    vx = -dx * 128 + round_mul(kq, dy, 16);
    vy = -dy * 128 - round_mul(kq, dx, 16);
    cx = longint'(a.sx) * 256 - vx;
    cy = longint'(a.sy) * 256 - vy;
    // sweep = 4*atan(bulge), vectoring toward the x axis
    x = QuarterTurn;
    y = b * 16384;
    z = 0;
    for (int k = 0; k < CordicIter; k++) begin
      if (y > 0) begin
        t = x + (y >>> k); y = y - (x >>> k); x = t; z += AtanStep[k];
      end else begin
        t = x - (y >>> k); y = y + (x >>> k); x = t; z -= AtanStep[k];
      end
    end
    sweep = z * 4;
    for (longint i = 0; i <= n; i++) begin
      phi = (sweep * i) / n;
      x = vx;
      y = vy;
      while (phi > QuarterTurn) begin
        t = -y; y = x; x = t; phi -= QuarterTurn;
      end
      while (phi < -QuarterTurn) begin
        t = y; y = -x; x = t; phi += QuarterTurn;
      end
      for (int k = 0; k < CordicIter; k++) begin
        if (phi >= 0) begin
          t = x - (y >>> k); y = y + (x >>> k); x = t; phi -= AtanStep[k];
        end else begin
          t = x + (y >>> k); y = y - (x >>> k); x = t; phi += AtanStep[k];
        end
      end
      x = round_mul(x, GainQ32, 32);
      y = round_mul(y, GainQ32, 32);
      v.x      = sat_q16((cx + x + 128) >>> 8);
      v.y      = sat_q16((cy + y + 128) >>> 8);
      v.z      = a.z;
      v.idx    = i[5:0];
      v.status = ST_VALID;
      v.last   = (i == n);
      vertex_q.push_back(v);
    end
  endtask

  task automatic report(input string what, input longint got, input longint want);
    err_cnt++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Program a register: setup phase, then access phase
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_SEGMENT_COUNT) seg_count_q = val[5:0];
    quiet_cycles = 0;
  endtask

  // Hold off until every expected vertex came back and the block went idle
  task automatic wait_idle();
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Offer one arc word after an optional random gap; tvalid stays high across back-to-back words
  task automatic send_arc(input arc_t a, input bit typed_invalid);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tdata  <= {3'd0, a.bulge, a.z, a.ey, a.ex, a.sy, a.sx};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (typed_invalid)
      vertex_q.push_back('{x: 0, y: 0, z: 0, idx: 0, status: ST_INVALID, last: 1'b1});
    else
      tessellate_arc(a);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF);
    endcase
  endfunction

  function automatic arc_t rand_arc();
    arc_t a;
    a.sx = rand_coord();
    a.sy = rand_coord();
    a.z  = $urandom();
    // mostly nearby ends, sometimes far apart or coincident
    case ($urandom_range(0, 9))
      0:       begin a.ex = a.sx; a.ey = a.sy; end
      1, 2:    begin a.ex = rand_coord(); a.ey = rand_coord(); end
      default: begin
        a.ex = a.sx + 32'($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh007FFFFF);
        a.ey = a.sy + 32'($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh007FFFFF);
      end
    endcase
    case ($urandom_range(0, 9))
      0:       a.bulge = '0;
      1, 2:    a.bulge = 21'($urandom());
      default: a.bulge = 21'($signed($urandom_range(0, 21'h3FFFF)) - 21'sh1FFFF);
    endcase
    return a;
  endfunction

  // Output side: check each accepted vertex word, stall in random bursts
  initial begin
    int unsigned stall_left;
    vertex_t     w;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        quiet_cycles = 0;
        if (vertex_q.size() == 0) begin
          err_cnt++;
          $display("%0t: vertex word with nothing expected", $realtime);
        end else begin
          w = vertex_q.pop_front();
          if ($signed(m_axis_tdata[31:0]) != w.x)
            report("vertex_x", $signed(m_axis_tdata[31:0]), w.x);
          if ($signed(m_axis_tdata[63:32]) != w.y)
            report("vertex_y", $signed(m_axis_tdata[63:32]), w.y);
          if ($signed(m_axis_tdata[95:64]) != w.z)
            report("vertex_z", $signed(m_axis_tdata[95:64]), w.z);
          if (m_axis_tdata[101:96] != w.idx)
            report("vertex_index", m_axis_tdata[101:96], w.idx);
          if (m_axis_tdata[103:102] != 2'd0)
            report("tdata fill", m_axis_tdata[103:102], 0);
          if (m_axis_tuser != w.status) report("status", m_axis_tuser, w.status);
          if (m_axis_tlast != w.last) report("last", m_axis_tlast, w.last);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (s_axis_tvalid && s_axis_tready) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    drow_t dir_tab [$];
    arc_t  a;
    err_cnt       = 0;
    no_idle       = 1'b0;
    seg_count_q   = SegReset;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;

    // Directed arcs: invalid inputs, bulge and coordinate extremes
    dir_tab = '{
      '{'{32'sh10000, 0, 32'sh20000, 0, 32'sh5000, 21'sd0}, 1'b1},
      '{'{32'sh10000, 32'sh30000, 32'sh10000, 32'sh30000, 7, 21'sd65536}, 1'b1},
      '{'{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
          32'sh80000000, -21'sd1048576}, 1'b1},
      '{'{0, 0, 32'sh20000, 0, 0, 21'sd65536}, 1'b0},
      '{'{0, 0, 32'sh20000, 0, 0, -21'sd65536}, 1'b0},
      '{'{0, 0, 0, 32'sh40000, 32'sh7FFFFFFF, 21'sd27146}, 1'b0},
      '{'{32'sh10000, 32'sh10000, 32'sh30000, 32'sh50000, 1, 21'sd524288}, 1'b0},
      '{'{32'sh10000, 32'sh10000, 32'sh30000, 32'sh50000, 1, -21'sd524288}, 1'b0},
      '{'{0, 0, 32'sh10000, 32'sh10000, 32'sh80000000, 21'sd1048575}, 1'b0},
      '{'{0, 0, 32'sh10000, 32'sh10000, 0, -21'sd1048576}, 1'b0},
      '{'{0, 0, 32'sh10000, 0, 0, 21'sd1}, 1'b0},
      '{'{0, 0, 32'sh10000, 0, 0, -21'sd1}, 1'b0},
      '{'{32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
          32'shFFFFFFFF, 21'sd65536}, 1'b0},
      '{'{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
          32'sh12345678, -21'sd200000}, 1'b0},
      '{'{32'sh7FFF0000, 32'sh7FFF0000, 32'sh7FFFFFFF, 32'sh7FFF8000, 3, 21'sd40000}, 1'b0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset value of segment_count first
    foreach (dir_tab[r]) send_arc(dir_tab[r].arc, dir_tab[r].typed_invalid);
    s_axis_tvalid <= 1'b0;

    // Zero acts as one segment; then the widest setting
    wait_idle();
    apb_write(ADDR_SEGMENT_COUNT, 32'd0);
    for (int k = 3; k < 9; k++) send_arc(dir_tab[k].arc, 1'b0);
    s_axis_tvalid <= 1'b0;
    wait_idle();
    apb_write(ADDR_SEGMENT_COUNT, 32'(MaxSegments));
    for (int k = 0; k < 4; k++) send_arc(rand_arc(), 1'b0);
    s_axis_tvalid <= 1'b0;

    // Random arcs, mostly with few segments to keep the run short
    for (int p = 0; p < 10; p++) begin
      wait_idle();
      apb_write(ADDR_SEGMENT_COUNT, p == 0 ? 32'd1 : 32'($urandom_range(0, 8)));
      if (p == 9) no_idle = 1'b1;
      for (int k = 0; k < RandomArcs / 10; k++) begin
        a = rand_arc();
        send_arc(a, 1'b0);
      end
      s_axis_tvalid <= 1'b0;
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && vertex_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (vertex_q.size() != 0)
        $display("%0d vertex words never arrived", vertex_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
sv/bat_pkg.sv
sv/bat_mul.sv
sv/bat_div.sv
sv/bulge_arc_tessellator.sv
sv/bat_checker.sv
verif/tb_bulge_arc_tessellator.sv
